// ===== sv/sidta_pkg.sv =====
// Shared constants, types and command/status structs for the decimal text converter.
package sidta_pkg;

    localparam int VALUE_BITS = 32;
    // Decimal digits needed for 2^(VALUE_BITS-1); log10(2) ~ 0.30103
    localparam int DIGITS     = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_BITS   = 4 * DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W  = $clog2(DIGITS + 1);

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;
    localparam logic [7:0] ASCII_MINUS = 8'd45;
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [7:0]                   char_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_step;
        logic emit_load;
        logic emit_sign;
    } dp_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic negative;
        logic out_last;
    } dp_status_t;

endpackage

// ===== sv/sidta_if.sv =====
// Valid/ready channel interfaces for the integer input and the character output.
interface sidta_value_if;
    import sidta_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sidta_char_if;
    import sidta_pkg::*;

    logic  valid;
    logic  ready;
    char_t character;
    logic  last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== sv/sidta_dp.sv =====
// Datapath: magnitude, shift-add-3 binary to BCD conversion and output character register.
module sidta_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sidta_pkg::value_t     value,
    input  sidta_pkg::dp_cmd_t    cmd,
    output sidta_pkg::dp_status_t status,
    output sidta_pkg::char_t      character,
    output logic                  last
);
    import sidta_pkg::*;

    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] bin_reg;
    logic [BCD_BITS-1:0]   bcd_reg;
    logic [BCD_BITS-1:0]   bcd_adj;
    logic [BCD_BITS-1:0]   bcd_shift;
    logic [BIT_CNT_W-1:0]  bitcnt_reg;
    logic [DIG_CNT_W-1:0]  digcnt_reg;
    logic                  neg_reg;
    char_t                 char_reg;
    logic                  last_reg;
    logic [3:0]            top_digit;

    function automatic logic bcd_ok(input logic [BCD_BITS-1:0] b);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (b[i*4 +: 4] > 4'd9)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    assign raw       = value;
    assign mag       = raw[VALUE_BITS-1] ? VALUE_BITS'(~raw + 1'b1) : raw;
    assign top_digit = bcd_reg[BCD_BITS-1 -: 4];

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= BCD_ADJ_MIN) ?
                                4'(bcd_reg[i*4 +: 4] + BCD_ADJ) : bcd_reg[i*4 +: 4];
        end
    end

    assign bcd_shift = {bcd_adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg    <= mag;
            bcd_reg    <= '0;
            neg_reg    <= raw[VALUE_BITS-1];
            bitcnt_reg <= '0;
            digcnt_reg <= DIG_CNT_W'(DIGITS);
        end
        else if (cmd.conv_step)
        begin
            bin_reg    <= {bin_reg[VALUE_BITS-2:0], 1'b0};
            bcd_reg    <= bcd_shift;
            bitcnt_reg <= bitcnt_reg + 1'b1;
        end
        else if (cmd.skip_step)
        begin
            bcd_reg    <= {bcd_reg[BCD_BITS-5:0], 4'b0};
            digcnt_reg <= digcnt_reg - 1'b1;
        end
        else if (cmd.emit_load)
        begin
            if (cmd.emit_sign)
            begin
                char_reg <= ASCII_MINUS;
                last_reg <= 1'b0;
            end
            else
            begin
                char_reg   <= ASCII_ZERO + {4'b0, top_digit};
                last_reg   <= (digcnt_reg == DIG_CNT_W'(1));
                bcd_reg    <= {bcd_reg[BCD_BITS-5:0], 4'b0};
                digcnt_reg <= digcnt_reg - 1'b1;
            end
        end
    end

    assign status.conv_done = (bitcnt_reg == BIT_CNT_W'(VALUE_BITS - 1));
    assign status.top_zero  = (top_digit == 4'd0) && (digcnt_reg != DIG_CNT_W'(1));
    assign status.negative  = neg_reg;
    assign status.out_last  = last_reg;
    assign character        = char_reg;
    assign last             = last_reg;

    a_bcd_digits_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.conv_step |=> bcd_ok(bcd_reg))
        else $error("BCD digit out of range after conversion step");

    a_char_is_text: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |=> (char_reg == ASCII_MINUS ||
                           (char_reg >= ASCII_ZERO && char_reg <= ASCII_NINE)))
        else $error("output character is neither a digit nor a minus sign");

endmodule

// ===== sv/sidta_ctrl.sv =====
// Controller state machine: load, convert, skip leading zeros, emit characters.
module sidta_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sidta_pkg::dp_cmd_t    cmd,
    input  sidta_pkg::dp_status_t status
);
    import sidta_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (status.conv_done)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (status.top_zero)
                begin
                    cmd.skip_step = 1'b1;
                end
                else
                begin
                    // sign goes out first; digits stay put until it is taken
                    cmd.emit_load = 1'b1;
                    cmd.emit_sign = status.negative;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_load = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a character is pending");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && status.out_last) |=> in_ready)
        else $error("input not ready after final character beat");

endmodule

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Top level: signed integer to decimal ASCII text converter.
//
//  channel  | dir | payload                       | beats per item
//  number   | in  | value (signed, VALUE_BITS)    | 1
//  text     | out | character (8), last (1)       | 1 to 11, last on final
//
// Per item: the number is accepted, converted one bit at a time by shift-add-3 steps,
// leading zero digits are dropped one at a time, the first character is loaded, then
// the characters go out one per beat. Dropped zeros plus emitted digits make DIGITS.
// Output stalls hold the character register and the controller in place.
// One number is in flight at a time; number.ready is high only when idle.
// Reset clears the controller alone; no memory is cleared.
module signed_int_to_decimal_ascii (
    input logic         clk,
    input logic         rst_n,
    sidta_value_if.sink number,
    sidta_char_if.source text
);
    import sidta_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sidta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (number.valid),
        .in_ready  (number.ready),
        .out_valid (text.valid),
        .out_ready (text.ready),
        .cmd       (cmd),
        .status    (status)
    );

    sidta_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (number.value),
        .cmd       (cmd),
        .status    (status),
        .character (text.character),
        .last      (text.last)
    );

endmodule
